// ----- rtl/buddy_page_allocator_macros.svh -----
// assertion helpers shared by the allocator modules
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// condition must never hold outside reset
`define BPA_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");

// antecedent must imply consequent in the same cycle
`define BPA_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// ----- rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int NUM_ORDERS = 13;
  localparam logic [3:0] TOP_ORDER = 4'd12;
  localparam int MEM_DEPTH  = 260;
  localparam logic [8:0] MEM_LAST = 9'd259;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_RESERVE = 2'd2,
    FUNC_INIT    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_BAD_SIZE = 2'd2,
    STAT_NOT_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_RESERVE,
    CMD_INIT,
    CMD_REJECT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  order;
    logic [11:0] page;
    status_t     status;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_WR,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_REL_RD,
    S_REL_WR,
    S_RSV_RD,
    S_RSV_CHK,
    S_DONE
  } back_state_t;

  // first memory word of each order's mark row
  function automatic logic [8:0] base_of(input logic [3:0] ord);
    logic [8:0] b;
    case (ord)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd128;
      4'd2:    b = 9'd192;
      4'd3:    b = 9'd224;
      4'd4:    b = 9'd240;
      4'd5:    b = 9'd248;
      4'd6:    b = 9'd252;
      4'd7:    b = 9'd254;
      4'd8:    b = 9'd255;
      4'd9:    b = 9'd256;
      4'd10:   b = 9'd257;
      4'd11:   b = 9'd258;
      4'd12:   b = 9'd259;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] words_of(input logic [3:0] ord);
    logic [7:0] w;
    case (ord)
      4'd0:    w = 8'd128;
      4'd1:    w = 8'd64;
      4'd2:    w = 8'd32;
      4'd3:    w = 8'd16;
      4'd4:    w = 8'd8;
      4'd5:    w = 8'd4;
      4'd6:    w = 8'd2;
      default: w = 8'd1;
    endcase
    return w;
  endfunction

  function automatic logic [8:0] addr_of(input logic [3:0] ord, input logic [11:0] blk);
    return base_of(ord) + {2'b00, blk[11:5]};
  endfunction

endpackage

// ----- rtl/buddy_page_allocator.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  request transaction: operation, count, page
// m_*       out        m_tvalid / m_tready  response transaction: status, result page
// cfg_*     in         cfg_valid/cfg_ready  total_pages register write
//
// one request at a time runs through the mark memory, each read-modify-write a read state then a write state:
// free and reserve do one read-modify-write per order walked (plus the reserve search),
// allocate scans one 32-bit word of the chosen order per read (up to 128 words at order 0)
// then one read-modify-write per split; initialize clears all 260 words and then visits each order.
// after reset all 260 mark memory words are cleared before the first request runs.
// up to two requests queue ahead of the engine; a waiting response holds the engine.
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // page_count[12:0], page_index[24:13], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_page[11:0], zero fill
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // total_pages[12:0]
);

  logic [12:0]   total_pages;
  logic [12:0]   pool;
  bpa_pkg::cmd_t front_cmd;
  bpa_pkg::cmd_t head_cmd;
  logic          q_full, q_avail, q_pop, q_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= 13'(bpa_pkg::MAX_PAGES);
    end else if (cfg_valid) begin
      total_pages <= cfg_data;
    end
  end

  assign pool = (total_pages > 13'(bpa_pkg::MAX_PAGES)) ? 13'(bpa_pkg::MAX_PAGES) : total_pages;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  bpa_front u_front (
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .pool    (pool),
    .cmd     (front_cmd)
  );

  bpa_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (head_cmd)
  );

  bpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pool      (pool),
    .cmd_avail (q_avail),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/bpa_front.sv -----
`timescale 1ns / 1ps
module bpa_front (
  input  logic [31:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic [12:0]        pool,
  output bpa_pkg::cmd_t      cmd
);

  logic [12:0] count;
  logic [11:0] page;
  logic [3:0]  k;
  logic [12:0] size;
  logic        bad_count;
  logic        bad_free;

  assign count = s_tdata[12:0];
  assign page  = s_tdata[24:13];

  // ceil log2 of the count
  always_comb begin
    k = bpa_pkg::TOP_ORDER;
    for (int i = bpa_pkg::NUM_ORDERS - 1; i >= 0; i--) begin
      if ((13'd1 << i) >= count) k = 4'(i);
    end
  end

  assign size      = 13'd1 << k;
  assign bad_count = (count == 13'd0) || (count > 13'(bpa_pkg::MAX_PAGES)) || (count > pool);
  assign bad_free  = (({1'b0, page} & (size - 13'd1)) != 13'd0) ||
                     (({1'b0, page} + size) > pool);

  always_comb begin
    cmd.op     = bpa_pkg::CMD_REJECT;
    cmd.order  = k;
    cmd.page   = page;
    cmd.status = bpa_pkg::STAT_OK;
    case (bpa_pkg::func_t'(s_tuser))
      bpa_pkg::FUNC_INIT: cmd.op = bpa_pkg::CMD_INIT;
      bpa_pkg::FUNC_ALLOC: begin
        if (bad_count) cmd.status = bpa_pkg::STAT_BAD_SIZE;
        else cmd.op = bpa_pkg::CMD_ALLOC;
      end
      bpa_pkg::FUNC_FREE: begin
        if (bad_count || bad_free) cmd.status = bpa_pkg::STAT_BAD_SIZE;
        else cmd.op = bpa_pkg::CMD_FREE;
      end
      bpa_pkg::FUNC_RESERVE: begin
        if ({1'b0, page} >= pool) cmd.status = bpa_pkg::STAT_NOT_FREE;
        else cmd.op = bpa_pkg::CMD_RESERVE;
      end
      default: cmd.op = bpa_pkg::CMD_REJECT;
    endcase
  end

endmodule

// ----- rtl/bpa_cmd_fifo.sv -----
`timescale 1ns / 1ps
`include "buddy_page_allocator_macros.svh"
module bpa_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpa_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output bpa_pkg::cmd_t head
);

  bpa_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  `BPA_ASSERT_NEVER(a_fill_range, clk, rst, fill == 2'd3)
  `BPA_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full)
  `BPA_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, avail)

endmodule

// ----- rtl/bpa_back.sv -----
`timescale 1ns / 1ps
`include "buddy_page_allocator_macros.svh"
module bpa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [12:0]   pool,
  input  logic          cmd_avail,
  input  bpa_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic [1:0]    m_tuser
);

  logic [31:0] mem [bpa_pkg::MEM_DEPTH];
  logic [31:0] rdata;

  bpa_pkg::back_state_t st, st_next;
  logic [3:0]  ord, ord_next;
  logic [3:0]  kord, kord_next;
  logic [11:0] blk, blk_next;
  logic [11:0] page, page_next;
  logic [6:0]  woff, woff_next;
  logic [3:0]  ri, ri_next;
  logic        rsv, rsv_next;
  logic        init_run, init_run_next;
  logic [8:0]  clr, clr_next;
  bpa_pkg::status_t res_status, res_status_next;
  logic [11:0] res_page, res_page_next;

  logic [12:0] cnt [bpa_pkg::NUM_ORDERS];
  logic        cnt_clr, cnt_we;
  logic [12:0] cnt_val;

  logic        mem_re, mem_we;
  logic [8:0]  mem_ra, mem_wa;
  logic [31:0] mem_wd;
  logic        out_load;

  logic [3:0]  avail_ord;
  logic        avail_found;
  logic [4:0]  low_bit;
  logic [11:0] found_blk;
  logic [4:0]  b, bb;
  logic [11:0] page_sh;
  logic [12:0] init_sh;
  logic [12:0] cnt_cur;
  logic [7:0]  words_of_ord;

  // smallest order at or above the wanted one that holds a free block
  always_comb begin
    avail_found = 1'b0;
    avail_ord   = 4'd0;
    for (int i = bpa_pkg::NUM_ORDERS - 1; i >= 0; i--) begin
      if (4'(i) >= cmd.order && cnt[i] != 13'd0) begin
        avail_found = 1'b1;
        avail_ord   = 4'(i);
      end
    end
  end

  always_comb begin
    low_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (rdata[i]) low_bit = 5'(i);
    end
  end

  assign found_blk    = {woff, low_bit};
  assign b            = blk[4:0];
  assign bb           = blk[4:0] ^ 5'd1;
  assign page_sh      = page >> ord;
  assign init_sh      = (pool >> ord) >> 1;
  assign cnt_cur      = cnt[ord];
  assign words_of_ord = bpa_pkg::words_of(ord);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst || cnt_clr) begin
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) cnt[i] <= 13'd0;
    end else if (cnt_we) begin
      cnt[ord] <= cnt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= bpa_pkg::S_CLEAR;
      clr      <= 9'd0;
      init_run <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      st       <= st_next;
      clr      <= clr_next;
      init_run <= init_run_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ord        <= ord_next;
    kord       <= kord_next;
    blk        <= blk_next;
    page       <= page_next;
    woff       <= woff_next;
    ri         <= ri_next;
    rsv        <= rsv_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    if (out_load) begin
      m_tdata <= {4'd0, res_page};
      m_tuser <= res_status;
    end
  end

  always_comb begin
    st_next         = st;
    ord_next        = ord;
    kord_next       = kord;
    blk_next        = blk;
    page_next       = page;
    woff_next       = woff;
    ri_next         = ri;
    rsv_next        = rsv;
    init_run_next   = init_run;
    clr_next        = clr;
    res_status_next = res_status;
    res_page_next   = res_page;
    cmd_pop  = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = 9'd0;
    mem_we   = 1'b0;
    mem_wa   = 9'd0;
    mem_wd   = 32'd0;
    cnt_clr  = 1'b0;
    cnt_we   = 1'b0;
    cnt_val  = cnt_cur;
    out_load = 1'b0;
    case (st)
      bpa_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr;
        cnt_clr  = 1'b1;
        clr_next = clr + 9'd1;
        if (clr == bpa_pkg::MEM_LAST) begin
          clr_next = 9'd0;
          if (init_run) begin
            ord_next = 4'd0;
            st_next  = bpa_pkg::S_INIT_WR;
          end else begin
            st_next = bpa_pkg::S_IDLE;
          end
        end
      end
      bpa_pkg::S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop         = 1'b1;
          res_status_next = bpa_pkg::STAT_OK;
          res_page_next   = 12'd0;
          case (cmd.op)
            bpa_pkg::CMD_INIT: begin
              init_run_next = 1'b1;
              st_next       = bpa_pkg::S_CLEAR;
            end
            bpa_pkg::CMD_ALLOC: begin
              if (!avail_found) begin
                res_status_next = bpa_pkg::STAT_NO_FREE;
                st_next         = bpa_pkg::S_DONE;
              end else begin
                ord_next  = avail_ord;
                kord_next = cmd.order;
                woff_next = 7'd0;
                st_next   = bpa_pkg::S_ALLOC_RD;
              end
            end
            bpa_pkg::CMD_FREE: begin
              ord_next = cmd.order;
              blk_next = cmd.page >> cmd.order;
              rsv_next = 1'b0;
              st_next  = bpa_pkg::S_REL_RD;
            end
            bpa_pkg::CMD_RESERVE: begin
              ord_next  = 4'd0;
              page_next = cmd.page;
              st_next   = bpa_pkg::S_RSV_RD;
            end
            default: begin
              res_status_next = cmd.status;
              st_next         = bpa_pkg::S_DONE;
            end
          endcase
        end
      end
      bpa_pkg::S_INIT_WR: begin
        // one aligned block per set bit of the pool size, or one top block
        if (pool[12] ? (ord == bpa_pkg::TOP_ORDER)
                     : (ord != bpa_pkg::TOP_ORDER && pool[ord])) begin
          mem_we  = 1'b1;
          mem_wa  = bpa_pkg::addr_of(ord, {init_sh[10:0], 1'b0});
          mem_wd  = 32'd1 << {init_sh[3:0], 1'b0};
          cnt_we  = 1'b1;
          cnt_val = 13'd1;
        end
        ord_next = ord + 4'd1;
        if (ord == bpa_pkg::TOP_ORDER) begin
          init_run_next = 1'b0;
          st_next       = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_ALLOC_RD: begin
        mem_re  = 1'b1;
        mem_ra  = bpa_pkg::base_of(ord) + {2'b00, woff};
        st_next = bpa_pkg::S_ALLOC_CHK;
      end
      bpa_pkg::S_ALLOC_CHK: begin
        if (rdata == 32'd0) begin
          woff_next = woff + 7'd1;
          st_next   = bpa_pkg::S_ALLOC_RD;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = bpa_pkg::base_of(ord) + {2'b00, woff};
          mem_wd  = rdata & ~(32'd1 << low_bit);
          cnt_we  = 1'b1;
          cnt_val = cnt_cur - 13'd1;
          if (ord == kord) begin
            res_page_next = found_blk << kord;
            st_next       = bpa_pkg::S_DONE;
          end else begin
            ord_next = ord - 4'd1;
            blk_next = found_blk << 1;
            st_next  = bpa_pkg::S_SPLIT_RD;
          end
        end
      end
      bpa_pkg::S_SPLIT_RD: begin
        mem_re  = 1'b1;
        mem_ra  = bpa_pkg::addr_of(ord, blk | 12'd1);
        st_next = bpa_pkg::S_SPLIT_WR;
      end
      bpa_pkg::S_SPLIT_WR: begin
        // upper half of the split goes back on the free marks
        mem_we  = 1'b1;
        mem_wa  = bpa_pkg::addr_of(ord, blk | 12'd1);
        mem_wd  = rdata | (32'd1 << (b | 5'd1));
        cnt_we  = 1'b1;
        cnt_val = cnt_cur + {12'd0, ~rdata[b | 5'd1]};
        if (ord == kord) begin
          res_page_next = blk << kord;
          st_next       = bpa_pkg::S_DONE;
        end else begin
          ord_next = ord - 4'd1;
          blk_next = blk << 1;
          st_next  = bpa_pkg::S_SPLIT_RD;
        end
      end
      bpa_pkg::S_REL_RD: begin
        mem_re  = 1'b1;
        mem_ra  = bpa_pkg::addr_of(ord, blk);
        st_next = bpa_pkg::S_REL_WR;
      end
      bpa_pkg::S_REL_WR: begin
        mem_we = 1'b1;
        mem_wa = bpa_pkg::addr_of(ord, blk);
        cnt_we = 1'b1;
        if (ord != bpa_pkg::TOP_ORDER && rdata[bb]) begin
          // buddy is free: drop both marks and climb one order
          mem_wd   = rdata & ~(32'd1 << b) & ~(32'd1 << bb);
          cnt_val  = cnt_cur - {12'd0, rdata[bb]} - {12'd0, rdata[b]};
          blk_next = blk >> 1;
          ord_next = ord + 4'd1;
          st_next  = bpa_pkg::S_REL_RD;
        end else begin
          mem_wd  = rdata | (32'd1 << b);
          cnt_val = cnt_cur + {12'd0, ~rdata[b]};
          if (!rsv) begin
            st_next = bpa_pkg::S_DONE;
          end else if (ri == 4'd0) begin
            res_page_next = page;
            st_next       = bpa_pkg::S_DONE;
          end else begin
            ri_next  = ri - 4'd1;
            ord_next = ri - 4'd1;
            blk_next = (page >> (ri - 4'd1)) ^ 12'd1;
            st_next  = bpa_pkg::S_REL_RD;
          end
        end
      end
      bpa_pkg::S_RSV_RD: begin
        mem_re  = 1'b1;
        mem_ra  = bpa_pkg::addr_of(ord, page_sh);
        st_next = bpa_pkg::S_RSV_CHK;
      end
      bpa_pkg::S_RSV_CHK: begin
        if (rdata[page_sh[4:0]]) begin
          mem_we  = 1'b1;
          mem_wa  = bpa_pkg::addr_of(ord, page_sh);
          mem_wd  = rdata & ~(32'd1 << page_sh[4:0]);
          cnt_we  = 1'b1;
          cnt_val = cnt_cur - 13'd1;
          if (ord == 4'd0) begin
            res_page_next = page;
            st_next       = bpa_pkg::S_DONE;
          end else begin
            // free every half below that misses the page
            rsv_next = 1'b1;
            ri_next  = ord - 4'd1;
            ord_next = ord - 4'd1;
            blk_next = (page >> (ord - 4'd1)) ^ 12'd1;
            st_next  = bpa_pkg::S_REL_RD;
          end
        end else if (ord == bpa_pkg::TOP_ORDER) begin
          res_status_next = bpa_pkg::STAT_NOT_FREE;
          st_next         = bpa_pkg::S_DONE;
        end else begin
          ord_next = ord + 4'd1;
          st_next  = bpa_pkg::S_RSV_RD;
        end
      end
      bpa_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          st_next  = bpa_pkg::S_IDLE;
        end
      end
      default: st_next = bpa_pkg::S_IDLE;
    endcase
  end

  `BPA_ASSERT_NEVER(a_one_port_use, clk, rst, mem_re && mem_we)
  `BPA_ASSERT_IMPLY(a_out_slot_free, clk, rst, out_load, !m_tvalid || m_tready)
  `BPA_ASSERT_IMPLY(a_scan_in_row, clk, rst, st == bpa_pkg::S_ALLOC_RD, 8'(woff) < words_of_ord)

endmodule

// ----- bench/buddy_page_allocator_checker.sv -----
`timescale 1ns / 1ps
module buddy_page_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    bpa_pkg::status_t status;
    logic [11:0]      page;
  } answer_t;

  bit          free_marks[0:8191];
  logic [12:0] pool_total;
  answer_t     answers_due[$];

  // marks of order o start at 8192 - 2*(4096 >> o)
  function automatic bit mark_ok(int o, int b);
    return o <= 12 && b >= 0 && b < (bpa_pkg::MAX_PAGES >> o);
  endfunction

  function automatic bit mark_rd(int o, int b);
    if (!mark_ok(o, b)) return 1'b0;
    return free_marks[2 * bpa_pkg::MAX_PAGES - 2 * (bpa_pkg::MAX_PAGES >> o) + b];
  endfunction

  function automatic void mark_wr(int o, int b, bit v);
    if (mark_ok(o, b))
      free_marks[2 * bpa_pkg::MAX_PAGES - 2 * (bpa_pkg::MAX_PAGES >> o) + b] = v;
  endfunction

  function automatic int pool_pages();
    return pool_total > bpa_pkg::MAX_PAGES ? bpa_pkg::MAX_PAGES : int'(pool_total);
  endfunction

  function automatic void clear_marks();
    foreach (free_marks[i]) free_marks[i] = 1'b0;
  endfunction

  function automatic void merge_up(int o, int b);
    while (o < 12 && mark_rd(o, b ^ 1)) begin
      mark_wr(o, b ^ 1, 1'b0);
      mark_wr(o, b, 1'b0);
      b = b >> 1;
      o++;
    end
    mark_wr(o, b, 1'b1);
  endfunction

  function automatic void fill_pool();
    int total, i, rest, k;
    total = pool_pages();
    i = 0;
    clear_marks();
    while (i < total) begin
      rest = total - i;
      k = 0;
      while ((2 << k) <= rest) k++;
      if (k > 12) k = 12;
      mark_wr(k, i >> k, 1'b1);
      i += 1 << k;
    end
  endfunction

  function automatic answer_t predict_request(bpa_pkg::func_t fn, int cnt, int pg);
    answer_t a;
    int k, j, blk, sz;
    bit hit;
    a.status = bpa_pkg::STAT_OK;
    a.page = '0;
    hit = 1'b0;
    blk = 0;
    case (fn)
      bpa_pkg::FUNC_INIT: fill_pool();
      bpa_pkg::FUNC_ALLOC, bpa_pkg::FUNC_FREE: begin
        if (cnt == 0 || cnt > 4096 || cnt > pool_pages()) begin
          a.status = bpa_pkg::STAT_BAD_SIZE;
        end else begin
          k = 0;
          while ((1 << k) < cnt) k++;
          if (fn == bpa_pkg::FUNC_ALLOC) begin
            for (j = k; j <= 12 && !hit; j++) begin
              for (blk = 0; blk < (bpa_pkg::MAX_PAGES >> j); blk++)
                if (mark_rd(j, blk)) begin
                  hit = 1'b1;
                  break;
                end
              if (hit) break;
            end
            if (!hit) begin
              a.status = bpa_pkg::STAT_NO_FREE;
            end else begin
              mark_wr(j, blk, 1'b0);
              while (j > k) begin
                j--;
                blk = blk << 1;
                mark_wr(j, blk + 1, 1'b1);
              end
              a.page = 12'(blk << k);
            end
          end else begin
            sz = 1 << k;
            if ((pg & (sz - 1)) != 0 || pg + sz > pool_pages()) a.status = bpa_pkg::STAT_BAD_SIZE;
            else merge_up(k, pg >> k);
          end
        end
      end
      default: begin
        if (pg < pool_pages()) begin
          for (k = 0; k <= 12; k++)
            if (mark_rd(k, pg >> k)) begin
              hit = 1'b1;
              break;
            end
        end
        if (!hit) begin
          a.status = bpa_pkg::STAT_NOT_FREE;
        end else begin
          mark_wr(k, pg >> k, 1'b0);
          for (j = k; j > 0; j--) merge_up(j - 1, (pg >> (j - 1)) ^ 1);
          a.page = 12'(pg);
        end
      end
    endcase
    return a;
  endfunction

  task automatic report(string what, int want, int got);
    $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      fail_count = 0;
      pool_total = 13'd4096;
      clear_marks();
      answers_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) pool_total = cfg_data;
      if (s_tvalid && s_tready)
        answers_due.push_back(predict_request(bpa_pkg::func_t'(s_tuser),
                                              int'(s_tdata[12:0]), int'(s_tdata[24:13])));
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          report("unexpected response transaction", 0, 1);
        end else begin
          want = answers_due.pop_front();
          if (m_tuser !== want.status) report("status", want.status, m_tuser);
          if (m_tdata[11:0] !== want.page) report("result_page", want.page, m_tdata[11:0]);
          if (m_tdata[15:12] !== 4'd0) report("tdata fill", 0, m_tdata[15:12]);
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    int page;
    int cnt;
  } block_t;

  typedef struct {
    bpa_pkg::func_t fn;
    int             cnt;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = bpa_pkg::FUNC_ALLOC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;
  int          fail_count, pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  block_t      live_blocks[$];
  request_t    in_flight[$];

  buddy_page_allocator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  buddy_page_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // follow granted blocks so that most frees hit real allocations
  always @(posedge clk) begin
    request_t r;
    if (!rst && m_tvalid && m_tready && in_flight.size() > 0) begin
      r = in_flight.pop_front();
      if (r.fn == bpa_pkg::FUNC_INIT) live_blocks.delete();
      else if (m_tuser == bpa_pkg::STAT_OK && r.fn == bpa_pkg::FUNC_ALLOC)
        live_blocks.push_back('{int'(m_tdata[11:0]), r.cnt});
      else if (m_tuser == bpa_pkg::STAT_OK && r.fn == bpa_pkg::FUNC_RESERVE)
        live_blocks.push_back('{int'(m_tdata[11:0]), 1});
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL buddy_page_allocator");
      $finish;
    end
  end

  task automatic send(bpa_pkg::func_t fn, int cnt, int pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {7'd0, 12'(pg), 13'(cnt)};
    do @(posedge clk); while (!s_tready);
    in_flight.push_back('{fn, cnt});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_total(int v);
    cfg_valid <= 1'b1;
    cfg_data  <= 13'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 1 << $urandom_range(0, 6));
    if (r < 95) return $urandom_range(1, 4096);
    return $urandom_range(0, 8191);
  endfunction

  task automatic random_request();
    int r, i, sz;
    block_t b;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send(bpa_pkg::FUNC_ALLOC, pick_count(), $urandom_range(0, 4095));
    end else if (r < 72 && live_blocks.size() > 0) begin
      i = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[i];
      live_blocks.delete(i);
      send(bpa_pkg::FUNC_FREE, b.cnt, b.page);
    end else if (r < 80) begin
      sz = 1 << $urandom_range(0, 12);
      send(bpa_pkg::FUNC_FREE, $urandom_range(sz / 2 + 1, sz),
           $urandom_range(0, 4095) & ~(sz - 1));
    end else if (r < 94) begin
      send(bpa_pkg::FUNC_RESERVE, $urandom_range(0, 8191), $urandom_range(0, 4095));
    end else if (r < 96) begin
      send(bpa_pkg::FUNC_INIT, $urandom_range(0, 8191), $urandom_range(0, 4095));
    end else begin
      send($urandom_range(0, 1) ? bpa_pkg::FUNC_FREE : bpa_pkg::FUNC_ALLOC,
           $urandom_range(0, 8191), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    int totals[7];
    totals = '{4096, 1, 8191, 0, 100, 0, 4096};
    totals[5] = $urandom_range(2, 4095);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty pool before the first initialize
    send(bpa_pkg::FUNC_ALLOC, 1, 0);
    send(bpa_pkg::FUNC_RESERVE, 1, 5);
    send(bpa_pkg::FUNC_INIT, 0, 0);
    send(bpa_pkg::FUNC_ALLOC, 1, 0);
    send(bpa_pkg::FUNC_ALLOC, 3, 0);
    send(bpa_pkg::FUNC_ALLOC, 4096, 0);
    send(bpa_pkg::FUNC_ALLOC, 0, 0);
    send(bpa_pkg::FUNC_ALLOC, 4097, 0);
    send(bpa_pkg::FUNC_ALLOC, 8191, 4095);
    send(bpa_pkg::FUNC_FREE, 1, 0);
    send(bpa_pkg::FUNC_FREE, 2, 1);
    send(bpa_pkg::FUNC_FREE, 2, 4095);
    send(bpa_pkg::FUNC_FREE, 0, 0);
    send(bpa_pkg::FUNC_RESERVE, 1, 4095);
    send(bpa_pkg::FUNC_RESERVE, 1, 4095);
    send(bpa_pkg::FUNC_RESERVE, 1, 100);
    send(bpa_pkg::FUNC_FREE, 1, 100);
    send(bpa_pkg::FUNC_INIT, 8191, 4095);
    send(bpa_pkg::FUNC_ALLOC, 4096, 0);
    send(bpa_pkg::FUNC_FREE, 4096, 0);
    send(bpa_pkg::FUNC_FREE, 4096, 0);
    send(bpa_pkg::FUNC_RESERVE, 0, 0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      drain();
      write_total(totals[ph]);
      send(bpa_pkg::FUNC_INIT, 1, 0);
      if (totals[ph] == 100) begin
        // block running past the end of the pool
        send(bpa_pkg::FUNC_FREE, 8, 96);
        send(bpa_pkg::FUNC_FREE, 128, 0);
        send(bpa_pkg::FUNC_RESERVE, 1, 100);
        send(bpa_pkg::FUNC_RESERVE, 1, 99);
      end
      repeat (140) random_request();
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS buddy_page_allocator");
    end else begin
      $display("FAIL buddy_page_allocator");
    end
    $finish;
  end

endmodule
